// ----- hw/rtl/crsf_pkg.sv -----
// shared constants, types and crc helper for the crsf frame builder
`default_nettype none

package crsf_pkg;

    // parameter defaults and fixed counts
    localparam int NUM_CHANNELS_DEF = 8;
    localparam int NUM_INPUTS       = 8;
    localparam int MAX_SLOTS        = 16;

    // field widths
    localparam int US_BITS    = 16;
    localparam int Y_BITS     = 10;
    localparam int SLOT_BITS  = 11;
    localparam int BYTE_BITS  = 8;

    // frame layout
    localparam int HDR_BYTES     = 3;
    localparam int PAYLOAD_BYTES = 22;
    localparam int PAYLOAD_BITS  = PAYLOAD_BYTES * BYTE_BITS;
    localparam int FRAME_BYTES   = HDR_BYTES + PAYLOAD_BYTES + 1;
    localparam int IDX_BITS      = $clog2(FRAME_BYTES);

    localparam logic [7:0] SYNC_BYTE = 8'hC8;
    localparam logic [7:0] LEN_BYTE  = 8'd24;
    localparam logic [7:0] TYPE_BYTE = 8'h16;
    localparam logic [7:0] CRC_POLY  = 8'hD5;

    // pulse width limits and output range
    localparam logic [US_BITS-1:0]   US_MIN  = 16'd1000;
    localparam logic [US_BITS-1:0]   US_MAX  = 16'd2000;
    localparam logic [Y_BITS-1:0]    US_SPAN = 10'd1000;
    localparam logic [SLOT_BITS-1:0] VAL_MIN = 11'd172;

    // floor(y * 1639 / 1000) as (y * 1639 * ceil(2^30 / 1000)) >> 30, exact for y <= 1000
    localparam int             SCALE_SHIFT = 30;
    localparam int             MULT_BITS   = 31;
    localparam int             PROD_BITS   = Y_BITS + MULT_BITS;
    localparam logic [MULT_BITS-1:0] SCALE_MULT = 31'd1759863138;

    // stage enables from the pipeline control to each channel lane
    typedef struct packed {
        logic take_raw;
        logic take_scaled;
    } stage_en_t;

    // one byte of crc-8, msb first, no reflection
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++)
        begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/crsf_if.sv -----
// valid/ready channel interfaces for channel sets and frame bytes
`default_nettype none

interface crsf_in_if
    import crsf_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [US_BITS-1:0] chan0_us;
    logic [US_BITS-1:0] chan1_us;
    logic [US_BITS-1:0] chan2_us;
    logic [US_BITS-1:0] chan3_us;
    logic [US_BITS-1:0] chan4_us;
    logic [US_BITS-1:0] chan5_us;
    logic [US_BITS-1:0] chan6_us;
    logic [US_BITS-1:0] chan7_us;

    modport source (
        output valid, chan0_us, chan1_us, chan2_us, chan3_us,
               chan4_us, chan5_us, chan6_us, chan7_us,
        input  ready
    );
    modport sink (
        input  valid, chan0_us, chan1_us, chan2_us, chan3_us,
               chan4_us, chan5_us, chan6_us, chan7_us,
        output ready
    );
endinterface

interface crsf_out_if
    import crsf_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [BYTE_BITS-1:0] frame_byte;
    logic                 frame_last;

    modport source (
        output valid, frame_byte, frame_last,
        input  ready
    );
    modport sink (
        input  valid, frame_byte, frame_last,
        output ready
    );
endinterface

`default_nettype wire

// ----- hw/rtl/crsf_channel_frame_builder_unit.sv -----
// top level of the crsf rc-channels frame builder
//
// channel | dir | payload                      | request means
// --------+-----+------------------------------+------------------------------
// chans   | in  | chan0_us..chan7_us, 16b each | one set of pulse widths
// frame   | out | frame_byte 8b, frame_last 1b | one byte of the 26-byte frame
//
// each set of channels gives 26 output bytes, one per cycle while frame.ready
// is high; the byte serialiser sets the sustained rate. a set taken on chans
// passes the clamp register and the scale register before its first byte.
// up to three sets are in flight: clamp register, scale register, serialiser.
// a new set is taken while a frame is still going out; stalls on frame hold
// the current byte and back up through the stages.
// rst_n clears the stage valid flags and the serialiser, no clearing pass.
`default_nettype none

module crsf_channel_frame_builder_unit
    import crsf_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    crsf_in_if.sink    chans,
    crsf_out_if.source frame
);

    // slots beyond the eight inputs are packed as zero
    localparam int NUM_USED = (NUM_CHANNELS < NUM_INPUTS) ? NUM_CHANNELS : NUM_INPUTS;

    logic [US_BITS-1:0]   raw_us [NUM_INPUTS];
    logic [SLOT_BITS-1:0] scaled [NUM_USED];
    logic [PAYLOAD_BITS-1:0] payload;

    logic      s1_valid_reg;
    logic      s1_valid_next;
    logic      s2_valid_reg;
    logic      s2_valid_next;
    logic      s1_free;
    logic      s2_free;
    logic      s1_adv;
    logic      in_fire;
    logic      ser_ready;
    stage_en_t en;

    assign raw_us[0] = chans.chan0_us;
    assign raw_us[1] = chans.chan1_us;
    assign raw_us[2] = chans.chan2_us;
    assign raw_us[3] = chans.chan3_us;
    assign raw_us[4] = chans.chan4_us;
    assign raw_us[5] = chans.chan5_us;
    assign raw_us[6] = chans.chan6_us;
    assign raw_us[7] = chans.chan7_us;

    // stage control: each stage frees when its content moves on
    assign s2_free     = !s2_valid_reg || ser_ready;
    assign s1_adv      = s1_valid_reg && s2_free;
    assign s1_free     = !s1_valid_reg || s2_free;
    assign chans.ready = s1_free;
    assign in_fire     = chans.valid && s1_free;

    assign s1_valid_next = in_fire || (s1_valid_reg && !s2_free);
    assign s2_valid_next = s1_adv || (s2_valid_reg && !ser_ready);

    assign en.take_raw    = in_fire;
    assign en.take_scaled = s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // one clamp-and-scale lane per packed channel
    for (genvar ch = 0; ch < NUM_USED; ch++)
    begin : g_lane
        crsf_scale u_scale (
            .clk    (clk),
            .en     (en),
            .raw_us (raw_us[ch]),
            .scaled (scaled[ch])
        );
    end

    // 11-bit slots, lsb first; uncovered bits stay zero
    always_comb
    begin
        payload = '0;
        for (int ch = 0; ch < NUM_USED; ch++)
        begin
            payload[ch*SLOT_BITS +: SLOT_BITS] = scaled[ch];
        end
    end

    crsf_ser u_ser (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (s2_valid_reg),
        .load_ready (ser_ready),
        .payload    (payload),
        .frame      (frame)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/crsf_scale.sv -----
// one channel lane: clamp register then scale-by-reciprocal register
`default_nettype none

module crsf_scale
    import crsf_pkg::*;
(
    input  wire logic                 clk,
    input  wire stage_en_t            en,
    input  wire logic [US_BITS-1:0]   raw_us,
    output logic      [SLOT_BITS-1:0] scaled
);

    logic [US_BITS-1:0]   y_full;
    logic [Y_BITS-1:0]    y_reg;
    logic [Y_BITS-1:0]    y_next;
    logic [PROD_BITS-1:0] prod;
    logic [SLOT_BITS-1:0] val_reg;
    logic [SLOT_BITS-1:0] val_next;

    // clamp to 1000..2000 and take the offset from 1000
    always_comb
    begin
        if (raw_us < US_MIN)
            y_full = '0;
        else if (raw_us > US_MAX)
            y_full = US_BITS'(US_SPAN);
        else
            y_full = raw_us - US_MIN;
        y_next = y_full[Y_BITS-1:0];
    end

    always_comb
    begin
        prod     = PROD_BITS'(y_reg) * PROD_BITS'(SCALE_MULT);
        val_next = prod[SCALE_SHIFT +: SLOT_BITS] + VAL_MIN;
    end

    always_ff @(posedge clk)
    begin
        if (en.take_raw)
            y_reg <= y_next;
        if (en.take_scaled)
            val_reg <= val_next;
    end

    assign scaled = val_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/crsf_ser.sv -----
// frame serialiser: header, payload and running crc, one byte per request
`default_nettype none

module crsf_ser
    import crsf_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    load_valid,
    output logic                         load_ready,
    input  wire logic [PAYLOAD_BITS-1:0] payload,
    crsf_out_if.source                   frame
);

    localparam int SHIFT_BITS = (HDR_BYTES + PAYLOAD_BYTES) * BYTE_BITS;
    localparam logic [IDX_BITS-1:0] CRC_IDX   = IDX_BITS'(FRAME_BYTES - 1);
    localparam logic [IDX_BITS-1:0] CRC_FIRST = IDX_BITS'(2);

    logic [SHIFT_BITS-1:0] shift_reg;
    logic [IDX_BITS-1:0]   idx_reg;
    logic                  active_reg;
    logic [7:0]            crc_reg;
    logic                  fire;
    logic                  on_crc;
    logic                  load;

    assign on_crc     = (idx_reg == CRC_IDX);
    assign fire       = active_reg && frame.ready;
    assign load_ready = !active_reg || (fire && on_crc);
    assign load       = load_valid && load_ready;

    assign frame.valid      = active_reg;
    assign frame.frame_byte = on_crc ? crc_reg : shift_reg[BYTE_BITS-1:0];
    assign frame.frame_last = on_crc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
            crc_reg    <= '0;
        end
        else if (load)
        begin
            active_reg <= 1'b1;
            idx_reg    <= '0;
            crc_reg    <= '0;
        end
        else if (fire)
        begin
            if (on_crc)
                active_reg <= 1'b0;
            idx_reg <= idx_reg + 1'b1;
            // crc covers type byte and payload
            if (idx_reg >= CRC_FIRST && !on_crc)
                crc_reg <= crc8_update(crc_reg, shift_reg[BYTE_BITS-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            shift_reg <= {payload, TYPE_BYTE, LEN_BYTE, SYNC_BYTE};
        else if (fire)
            shift_reg <= shift_reg >> BYTE_BITS;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/crsf_checker.sv -----
// port-level checker for the frame builder and its bind
`default_nettype none

module crsf_checker
    import crsf_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_valid,
    input wire logic                 in_ready,
    input wire logic                 out_valid,
    input wire logic                 out_ready,
    input wire logic [BYTE_BITS-1:0] frame_byte,
    input wire logic                 frame_last
);

    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(FRAME_BYTES - 1);
    localparam logic [2:0]          MAX_PEND = 3'd3;

    logic [IDX_BITS-1:0] cnt_reg;
    logic [2:0]          pend_reg;
    logic                in_fire;
    logic                out_fire;
    logic                frame_start;

    assign in_fire     = in_valid && in_ready;
    assign out_fire    = out_valid && out_ready;
    assign frame_start = out_fire && (cnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            pend_reg <= '0;
        end
        else
        begin
            if (out_fire)
                cnt_reg <= (cnt_reg == LAST_IDX) ? '0 : cnt_reg + 1'b1;
            pend_reg <= pend_reg + {2'b0, in_fire} - {2'b0, frame_start};
        end
    end

    // a stalled byte holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frame_byte) && $stable(frame_last))
        else $error("output byte changed under stall");

    // header bytes in order at the head of each frame
    a_header: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire |-> ((cnt_reg == '0) ? frame_byte == SYNC_BYTE : 1'b1)
                  && ((cnt_reg == 1)  ? frame_byte == LEN_BYTE  : 1'b1)
                  && ((cnt_reg == 2)  ? frame_byte == TYPE_BYTE : 1'b1))
        else $error("frame header byte wrong");

    // last flag exactly on the 26th byte
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (frame_last == (cnt_reg == LAST_IDX)))
        else $error("frame_last misplaced");

    // no frame without an accepted set, and no more than three sets held
    a_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_start |-> pend_reg != '0) and (pend_reg <= MAX_PEND))
        else $error("frame count does not match accepted sets");

endmodule

bind crsf_channel_frame_builder_unit crsf_checker u_crsf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (chans.valid),
    .in_ready   (chans.ready),
    .out_valid  (frame.valid),
    .out_ready  (frame.ready),
    .frame_byte (frame.frame_byte),
    .frame_last (frame.frame_last)
);

`default_nettype wire

// ----- bench/tb_top.sv -----
// self-checking bench for the crsf rc-channels frame builder
`default_nettype none

module tb_top;
    import crsf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // upper end of the scaled range, the span follows from it
    localparam int VAL_TOP      = 1811;
    localparam int SCALE_NUM    = VAL_TOP - VAL_MIN;
    localparam int IDLE_PERCENT = 32;
    localparam int RANDOM_SETS  = 450;

    // one set of pulse widths, channel 0 in the lowest 16 bits
    typedef logic [NUM_INPUTS-1:0][US_BITS-1:0] chan_set_t;

    // one byte of the frame as it should leave the block
    typedef struct packed {
        logic [BYTE_BITS-1:0] frame_byte;
        logic                 frame_last;
    } frame_beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    crsf_in_if  chans_if ();
    crsf_out_if frame_if ();

    crsf_channel_frame_builder_unit dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .chans (chans_if.sink),
        .frame (frame_if.source)
    );

    always #10 clk = ~clk;

    chan_set_t   sets_to_send[$];
    frame_beat_t frame_bytes_due[$];
    int          sets_taken;
    int          sets_queued;
    int          fault_count;
    logic        steady;

    // a long run of requests with neither side holding back
    assign steady = (sets_taken >= 180) && (sets_taken < 280);

    // clamp to the legal pulse range, then map 1000..2000 onto 172..1811, truncating
    function automatic int scaled_width(input logic [US_BITS-1:0] us);
        int x;
        x = us;
        if (x < US_MIN)
            x = US_MIN;
        if (x > US_MAX)
            x = US_MAX;
        return (x - US_MIN) * SCALE_NUM / US_SPAN + VAL_MIN;
    endfunction

    // works out the whole 26-byte frame for one set and queues it byte by byte
    function automatic void frame_for_set(input chan_set_t set);
        logic [PAYLOAD_BITS-1:0] payload;
        logic [BYTE_BITS-1:0]    frame_img [FRAME_BYTES];
        logic [BYTE_BITS-1:0]    crc;
        logic [31:0]             v;
        int                      pos;
        frame_beat_t             beat;
        payload = '0;
        pos = 0;
        // slots beyond the eight inputs are packed as zero bits
        for (int ch = 0; ch < dut.NUM_CHANNELS && ch < MAX_SLOTS; ch++)
        begin
            v = '0;
            if (ch < NUM_INPUTS)
                v = scaled_width(set[ch]);
            for (int b = 0; b < SLOT_BITS; b++)
            begin
                if (pos < PAYLOAD_BITS)
                    payload[pos] = v[b];
                pos++;
            end
        end
        frame_img[0] = SYNC_BYTE;
        frame_img[1] = LEN_BYTE;
        frame_img[2] = TYPE_BYTE;
        for (int i = 0; i < PAYLOAD_BYTES; i++)
            frame_img[HDR_BYTES + i] = payload[i*BYTE_BITS +: BYTE_BITS];
        // crc-8 over the type byte and the payload, msb first
        crc = '0;
        for (int i = 2; i < FRAME_BYTES - 1; i++)
        begin
            crc = crc ^ frame_img[i];
            for (int k = 0; k < BYTE_BITS; k++)
                crc = crc[7] ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
        end
        frame_img[FRAME_BYTES - 1] = crc;
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            beat.frame_byte = frame_img[i];
            beat.frame_last = (i == FRAME_BYTES - 1);
            frame_bytes_due.push_back(beat);
        end
    endfunction

    // random pulse width: mostly legal, some near the clamp edges, some anything
    function automatic logic [US_BITS-1:0] random_width();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return 16'($urandom_range(US_MAX, US_MIN));
        if (pick < 78)
            return 16'($urandom_range(US_MIN + 10, US_MIN - 10));
        if (pick < 86)
            return 16'($urandom_range(US_MAX + 10, US_MAX - 10));
        return 16'($urandom);
    endfunction

    function automatic chan_set_t uniform_set(input logic [US_BITS-1:0] us);
        chan_set_t set;
        for (int ch = 0; ch < NUM_INPUTS; ch++)
            set[ch] = us;
        return set;
    endfunction

    // driver: presents the next set of pulse widths; a taken request is predicted here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chans_if.valid    <= 1'b0;
            chans_if.chan0_us <= '0;
            chans_if.chan1_us <= '0;
            chans_if.chan2_us <= '0;
            chans_if.chan3_us <= '0;
            chans_if.chan4_us <= '0;
            chans_if.chan5_us <= '0;
            chans_if.chan6_us <= '0;
            chans_if.chan7_us <= '0;
            sets_taken        <= 0;
        end
        else
        begin
            if (chans_if.valid && chans_if.ready)
            begin
                frame_for_set({chans_if.chan7_us, chans_if.chan6_us, chans_if.chan5_us,
                               chans_if.chan4_us, chans_if.chan3_us, chans_if.chan2_us,
                               chans_if.chan1_us, chans_if.chan0_us});
                sets_taken <= sets_taken + 1;
            end
            // only move on once the current request has gone or none is showing
            if (!chans_if.valid || chans_if.ready)
            begin
                if (sets_to_send.size() > 0 &&
                    (steady || $urandom_range(99) >= IDLE_PERCENT))
                begin
                    chan_set_t next_set;
                    next_set = sets_to_send.pop_front();
                    chans_if.valid    <= 1'b1;
                    chans_if.chan0_us <= next_set[0];
                    chans_if.chan1_us <= next_set[1];
                    chans_if.chan2_us <= next_set[2];
                    chans_if.chan3_us <= next_set[3];
                    chans_if.chan4_us <= next_set[4];
                    chans_if.chan5_us <= next_set[5];
                    chans_if.chan6_us <= next_set[6];
                    chans_if.chan7_us <= next_set[7];
                end
                else
                begin
                    chans_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each frame byte against the oldest one due, stalls at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_if.ready <= 1'b0;
            fault_count    <= 0;
        end
        else
        begin
            if (frame_if.valid && frame_if.ready)
            begin
                if (frame_bytes_due.size() == 0)
                begin
                    $error("frame byte %0h with nothing due", frame_if.frame_byte);
                    fault_count <= fault_count + 1;
                end
                else
                begin
                    frame_beat_t due;
                    int          miss;
                    due = frame_bytes_due.pop_front();
                    miss = 0;
                    if (frame_if.frame_byte !== due.frame_byte)
                    begin
                        $error("frame_byte: expected %0h, got %0h",
                               due.frame_byte, frame_if.frame_byte);
                        miss++;
                    end
                    if (frame_if.frame_last !== due.frame_last)
                    begin
                        $error("frame_last: expected %0b, got %0b",
                               due.frame_last, frame_if.frame_last);
                        miss++;
                    end
                    fault_count <= fault_count + miss;
                end
            end
            frame_if.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // stimulus, reset and the end of the run
    initial
    begin
        chan_set_t set;
        chans_if.valid    = 1'b0;
        chans_if.chan0_us = '0;
        chans_if.chan1_us = '0;
        chans_if.chan2_us = '0;
        chans_if.chan3_us = '0;
        chans_if.chan4_us = '0;
        chans_if.chan5_us = '0;
        chans_if.chan6_us = '0;
        chans_if.chan7_us = '0;
        frame_if.ready    = 1'b0;

        // directed sets: range ends, clamping from both sides, truncation, bit patterns
        sets_to_send.push_back(uniform_set(US_MIN));
        sets_to_send.push_back(uniform_set(US_MAX));
        sets_to_send.push_back(uniform_set(16'd0));
        sets_to_send.push_back(uniform_set(16'hFFFF));
        sets_to_send.push_back(uniform_set(US_MIN - 1));
        sets_to_send.push_back(uniform_set(US_MAX + 1));
        sets_to_send.push_back(uniform_set(16'd1500));
        sets_to_send.push_back(uniform_set(US_MIN + 1));
        sets_to_send.push_back(uniform_set(US_MAX - 1));
        sets_to_send.push_back(uniform_set(16'h8000));
        sets_to_send.push_back(uniform_set(16'h5555));
        sets_to_send.push_back(uniform_set(16'hAAAA));
        // alternating extremes, so a spill would land in the neighbouring slot
        for (int ch = 0; ch < NUM_INPUTS; ch++)
            set[ch] = ch[0] ? 16'hFFFF : 16'd0;
        sets_to_send.push_back(set);
        for (int ch = 0; ch < NUM_INPUTS; ch++)
            set[ch] = ch[0] ? US_MIN : US_MAX;
        sets_to_send.push_back(set);
        // a ramp across the range, one step per channel
        for (int ch = 0; ch < NUM_INPUTS; ch++)
            set[ch] = 16'(US_MIN + ch * 143);
        sets_to_send.push_back(set);
        // one channel at full scale, the rest at the bottom
        for (int hot = 0; hot < NUM_INPUTS; hot++)
        begin
            set = uniform_set(US_MIN);
            set[hot] = US_MAX;
            sets_to_send.push_back(set);
        end

        for (int n = 0; n < RANDOM_SETS; n++)
        begin
            for (int ch = 0; ch < NUM_INPUTS; ch++)
                set[ch] = random_width();
            sets_to_send.push_back(set);
        end
        sets_queued = sets_to_send.size();

        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // every set taken and every byte seen, then a short drain for stray output
        while (sets_taken < sets_queued || frame_bytes_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (fault_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
